FILE: rtl/core/assert_macros.svh
// Assertion macros used by the release controller (dmb_ctrl) of the motion blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMB_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/dmb_pkg.sv
package dmb_pkg;

    // Geometry of the filter and of the line store.
    localparam int MAX_WIDTH   = 1024;
    localparam int KERNEL_SIZE = 9;
    localparam int HALF_K      = KERNEL_SIZE / 2;
    localparam int STORE_DEPTH = KERNEL_SIZE * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = $clog2(KERNEL_SIZE);
    localparam int MAX_RESULTS = HALF_K + 1;
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

    // Field and register widths.
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int SCALE_W    = 24;
    localparam int BIAS_W     = 9;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = $clog2(KERNEL_SIZE * 255 + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Result buffer sizing.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS         = 3'd3;

    // Input word kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_in_run;
        logic       frame_done;
    } out_word_t;

    // Effective settings as the datapath sees them.
    typedef struct packed {
        logic [WIDTH_W-1:0]       width_m1;
        logic [HEIGHT_W-1:0]      height_m1;
        logic [SCALE_W-1:0]       scale_q16;
        logic signed [BIAS_W-1:0] bias;
    } cfg_t;

    // Line store write travelling down the cell chain.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } wr_t;

    // Output request travelling down the cell chain, gathering the sums.
    typedef struct packed {
        logic                valid;
        logic [WIDTH_W-1:0]  col;
        logic [HEIGHT_W-1:0] row;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic                frame_done;
        logic [SUM_W-1:0]    sum_r;
        logic [SUM_W-1:0]    sum_g;
        logic [SUM_W-1:0]    sum_b;
    } tok_t;

endpackage

FILE: rtl/core/diagonal_motion_blur_convolver.sv
// Channel   | Ports                          | Word
// ----------+--------------------------------+------------------------------------------
// input     | s_valid, s_ready, s_data       | kind, red, green, blue
// result    | m_valid, m_ready, m_data       | out_red, out_green, out_blue, flags
// config    | cfg_wr_en, cfg_index, cfg_wr_data | one register write per enabled cycle
//
// One input word per clock is taken while no release is in progress; a pixel
// releases up to five results, one per clock while the result buffer has room.
// Releases are set by the single release sequencer; a released result passes through
// the nine tap cells, two scaling stages and the result buffer.
// Reset is synchronous and needs no clearing pass; the line store holds no reset value.
// A stalled result side fills the 16-word result buffer, after which releases and
// then input words wait.
module diagonal_motion_blur_convolver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dmb_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dmb_pkg::out_word_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [dmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmb_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import dmb_pkg::*;

    logic [WIDTH_W-1:0]       image_width_reg;
    logic [HEIGHT_W-1:0]      image_height_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    cfg_t                     cfg;
    logic                     geom_clear;
    logic                     pop;
    logic                     push_valid;
    out_word_t                push_data;
    tok_t                     tok_chain [KERNEL_SIZE+1];
    wr_t                      wr_chain [KERNEL_SIZE+1];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_W'(1024);
            image_height_reg <= HEIGHT_W'(768);
            scale_reg        <= SCALE_W'(7282);
            bias_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                CFG_SCALE_Q16:    scale_reg        <= cfg_wr_data[SCALE_W-1:0];
                CFG_BIAS:         bias_reg         <= signed'(cfg_wr_data[BIAS_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Effective geometry: width held to 1..MAX_WIDTH, a zero height taken as one row.
    always_comb begin
        if (image_width_reg == '0) begin
            cfg.width_m1 = '0;
        end else if (image_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            cfg.width_m1 = WIDTH_W'(MAX_WIDTH - 1);
        end else begin
            cfg.width_m1 = image_width_reg - 1'b1;
        end
        cfg.height_m1 = (image_height_reg == '0) ? '0 : image_height_reg - 1'b1;
        cfg.scale_q16 = scale_reg;
        cfg.bias      = bias_reg;
    end

    assign geom_clear = cfg_wr_en
        && ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));
    assign pop = m_valid && m_ready;

    dmb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .geom_clear (geom_clear),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .pop        (pop),
        .wr_out     (wr_chain[0]),
        .tok_out    (tok_chain[0])
    );

    // One cell per diagonal tap.
    for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
        dmb_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tap     (SLOT_W'(k)),
            .cfg     (cfg),
            .tok_in  (tok_chain[k]),
            .wr_in   (wr_chain[k]),
            .tok_out (tok_chain[k+1]),
            .wr_out  (wr_chain[k+1])
        );
    end

    dmb_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .tok_in     (tok_chain[KERNEL_SIZE]),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    dmb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: rtl/core/dmb_ctrl.sv
`include "assert_macros.svh"

module dmb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmb_pkg::cfg_t     cfg,
    input  logic              geom_clear,
    input  logic              s_valid,
    output logic              s_ready,
    input  dmb_pkg::in_word_t s_data,
    input  logic              pop,
    output dmb_pkg::wr_t      wr_out,
    output dmb_pkg::tok_t     tok_out
);
    import dmb_pkg::*;

    logic [WIDTH_W-1:0]  in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] in_row_reg, in_row_next;
    logic [SLOT_W-1:0]   in_slot_reg, in_slot_next;
    logic [WIDTH_W-1:0]  out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                active_reg, active_next;
    logic                kind_reg, kind_next;
    logic [HEIGHT_W-1:0] item_row_reg, item_row_next;
    logic [RUN_W-1:0]    run_cnt_reg, run_cnt_next;
    logic [CNT_W-1:0]    credit_reg, credit_next;
    wr_t                 wr_reg, wr_next;
    tok_t                tok_reg, tok_next;

    logic                cond_now, cond_next, frame_end, row_wrap, last, emit, done, accept;
    logic                pix_take;
    logic [WIDTH_W-1:0]  nx_col, in_col_b;
    logic [HEIGHT_W-1:0] nx_row, in_row_b;
    logic [SLOT_W-1:0]   nx_slot, in_slot_b;

    // True when the window around (col, row) has fully arrived.
    function automatic logic win_ready(
        input logic [WIDTH_W-1:0]  col,
        input logic [HEIGHT_W-1:0] row,
        input logic [WIDTH_W-1:0]  icol,
        input logic [HEIGHT_W-1:0] irow,
        input logic [WIDTH_W-1:0]  wm1,
        input logic [HEIGHT_W-1:0] hm1
    );
        logic [WIDTH_W:0]    c_ext;
        logic [HEIGHT_W:0]   r_ext;
        logic [WIDTH_W-1:0]  cc;
        logic [HEIGHT_W-1:0] rr;
        c_ext = {1'b0, col} + (WIDTH_W+1)'(HALF_K);
        r_ext = {1'b0, row} + (HEIGHT_W+1)'(HALF_K);
        cc = (c_ext > {1'b0, wm1}) ? wm1 : c_ext[WIDTH_W-1:0];
        rr = (r_ext > {1'b0, hm1}) ? hm1 : r_ext[HEIGHT_W-1:0];
        return (irow > rr) || ((irow == rr) && (icol > cc));
    endfunction

    // True when the current item may release the output at (col, row).
    function automatic logic may_emit(
        input logic                kind,
        input logic [RUN_W-1:0]    n,
        input logic [WIDTH_W-1:0]  col,
        input logic [HEIGHT_W-1:0] row,
        input logic [HEIGHT_W-1:0] item_row,
        input logic [WIDTH_W-1:0]  icol,
        input logic [HEIGHT_W-1:0] irow,
        input logic [WIDTH_W-1:0]  wm1,
        input logic [HEIGHT_W-1:0] hm1
    );
        logic base;
        base = (row <= hm1) && win_ready(col, row, icol, irow, wm1, hm1);
        if (kind == KIND_FLUSH) begin
            return (n == '0) && base;
        end
        return (n < RUN_W'(MAX_RESULTS))
            && (({1'b0, row} + (HEIGHT_W+1)'(HALF_K)) <= {1'b0, item_row}) && base;
    endfunction

    // Release decision for the current item.
    always_comb begin
        cond_now = may_emit(kind_reg, run_cnt_reg, out_col_reg, out_row_reg, item_row_reg,
                            in_col_reg, in_row_reg, cfg.width_m1, cfg.height_m1);
        frame_end = (out_col_reg == cfg.width_m1) && (out_row_reg == cfg.height_m1);
        row_wrap  = (out_col_reg == cfg.width_m1);
        nx_col  = row_wrap ? '0 : out_col_reg + 1'b1;
        nx_row  = row_wrap ? out_row_reg + 1'b1 : out_row_reg;
        if (row_wrap) begin
            nx_slot = (out_slot_reg == SLOT_W'(KERNEL_SIZE - 1)) ? '0 : out_slot_reg + 1'b1;
        end else begin
            nx_slot = out_slot_reg;
        end
        cond_next = may_emit(kind_reg, run_cnt_reg + 1'b1, nx_col, nx_row, item_row_reg,
                             in_col_reg, in_row_reg, cfg.width_m1, cfg.height_m1);
        last    = frame_end || !cond_next;
        emit    = active_reg && cond_now && (credit_reg < CNT_W'(FIFO_DEPTH));
        done    = active_reg && (!cond_now || (emit && last));
        s_ready = !active_reg || done;
        accept  = s_valid && s_ready;
    end

    // Counter and item bookkeeping.
    always_comb begin
        in_col_b  = (emit && frame_end) ? '0 : in_col_reg;
        in_row_b  = (emit && frame_end) ? '0 : in_row_reg;
        in_slot_b = (emit && frame_end) ? '0 : in_slot_reg;
        pix_take  = accept && (s_data.kind == KIND_PIXEL) && (in_row_b <= cfg.height_m1);

        in_col_next  = in_col_b;
        in_row_next  = in_row_b;
        in_slot_next = in_slot_b;
        if (pix_take) begin
            if (in_col_b == cfg.width_m1) begin
                in_col_next  = '0;
                in_row_next  = in_row_b + 1'b1;
                in_slot_next = (in_slot_b == SLOT_W'(KERNEL_SIZE - 1)) ? '0 : in_slot_b + 1'b1;
            end else begin
                in_col_next = in_col_b + 1'b1;
            end
        end

        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        if (emit) begin
            out_col_next  = frame_end ? '0 : nx_col;
            out_row_next  = frame_end ? '0 : nx_row;
            out_slot_next = frame_end ? '0 : nx_slot;
        end

        active_next   = active_reg;
        kind_next     = kind_reg;
        item_row_next = item_row_reg;
        run_cnt_next  = emit ? run_cnt_reg + 1'b1 : run_cnt_reg;
        if (accept) begin
            active_next   = pix_take || (s_data.kind == KIND_FLUSH);
            kind_next     = s_data.kind;
            item_row_next = in_row_b;
            run_cnt_next  = '0;
        end else if (done) begin
            active_next = 1'b0;
        end

        credit_next = credit_reg + CNT_W'(emit) - CNT_W'(pop);

        wr_next.en   = pix_take;
        wr_next.addr = ADDR_W'(in_slot_b) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_b);
        wr_next.data = {s_data.red, s_data.green, s_data.blue};

        tok_next.valid      = emit;
        tok_next.col        = out_col_reg;
        tok_next.row        = out_row_reg;
        tok_next.slot       = out_slot_reg;
        tok_next.last       = last;
        tok_next.frame_done = frame_end;
        tok_next.sum_r      = '0;
        tok_next.sum_g      = '0;
        tok_next.sum_b      = '0;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || geom_clear) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            run_cnt_reg   <= '0;
            credit_reg    <= '0;
            wr_reg.en     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            active_reg  <= active_next;
            run_cnt_reg <= run_cnt_next;
            credit_reg  <= credit_next;
            wr_reg      <= wr_next;
            tok_reg     <= tok_next;
        end
    end

    // Item payload needs no reset.
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        item_row_reg <= item_row_next;
    end

    assign wr_out  = wr_reg;
    assign tok_out = tok_reg;

    `DMB_ASSERT_IMPLIES(a_credit_bound, aclk, aresetn, 1'b1, credit_reg <= CNT_W'(FIFO_DEPTH))
    `DMB_ASSERT_NEXT(a_frame_restart, aclk, aresetn, emit && frame_end && !accept, (out_row_reg == '0) && (out_col_reg == '0) && (in_row_reg == '0))
    `DMB_ASSERT_IMPLIES(a_flush_single, aclk, aresetn, active_reg && (kind_reg == KIND_FLUSH), run_cnt_reg <= RUN_W'(1))
    `DMB_ASSERT_IMPLIES(a_output_behind, aclk, aresetn, emit, out_row_reg <= in_row_reg)

endmodule

FILE: rtl/core/dmb_cell.sv
module dmb_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [dmb_pkg::SLOT_W-1:0]   tap,
    input  dmb_pkg::cfg_t                cfg,
    input  dmb_pkg::tok_t                tok_in,
    input  dmb_pkg::wr_t                 wr_in,
    output dmb_pkg::tok_t                tok_out,
    output dmb_pkg::wr_t                 wr_out
);
    import dmb_pkg::*;

    // Private copy of the line store; writes arrive in step with the requests.
    logic [PIX_W-1:0] store [STORE_DEPTH];

    logic [PIX_W-1:0]           rd_data_reg;
    tok_t                       tok_reg;
    wr_t                        wr_reg;
    logic signed [WIDTH_W+1:0]  dx;
    logic signed [HEIGHT_W+1:0] dy;
    logic signed [SLOT_W+1:0]   slot_mid;
    logic [SLOT_W:0]            slot_bot;
    logic [HEIGHT_W-1:0]        rows_left;
    logic [WIDTH_W-1:0]         col_sel;
    logic [SLOT_W-1:0]          slot_sel;
    logic [ADDR_W-1:0]          rd_addr;

    // Clamp this tap's coordinates to the image and find its row slot.
    always_comb begin
        dx = signed'((WIDTH_W+2)'(tok_in.col)) + signed'((WIDTH_W+2)'(tap))
           - signed'((WIDTH_W+2)'(HALF_K));
        dy = signed'((HEIGHT_W+2)'(tok_in.row)) + signed'((HEIGHT_W+2)'(tap))
           - signed'((HEIGHT_W+2)'(HALF_K));
        if (dx < 0) begin
            col_sel = '0;
        end else if (dx > signed'((WIDTH_W+2)'(cfg.width_m1))) begin
            col_sel = cfg.width_m1;
        end else begin
            col_sel = dx[WIDTH_W-1:0];
        end

        // Rows below the frame fold onto the last row, a few rows past this one.
        rows_left = cfg.height_m1 - tok_in.row;
        slot_bot  = (SLOT_W+1)'(tok_in.slot) + (SLOT_W+1)'(rows_left[SLOT_W-1:0]);
        if (slot_bot >= (SLOT_W+1)'(KERNEL_SIZE)) begin
            slot_bot = slot_bot - (SLOT_W+1)'(KERNEL_SIZE);
        end
        slot_mid = signed'((SLOT_W+2)'(tok_in.slot)) + signed'((SLOT_W+2)'(tap))
                 - signed'((SLOT_W+2)'(HALF_K));
        if (slot_mid < 0) begin
            slot_mid = slot_mid + signed'((SLOT_W+2)'(KERNEL_SIZE));
        end else if (slot_mid >= signed'((SLOT_W+2)'(KERNEL_SIZE))) begin
            slot_mid = slot_mid - signed'((SLOT_W+2)'(KERNEL_SIZE));
        end

        if (dy < 0) begin
            slot_sel = '0;
        end else if (dy > signed'((HEIGHT_W+2)'(cfg.height_m1))) begin
            slot_sel = slot_bot[SLOT_W-1:0];
        end else begin
            slot_sel = slot_mid[SLOT_W-1:0];
        end
        rd_addr = ADDR_W'(slot_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);
    end

    // Store port: the read sees the contents from before this cycle's write.
    always_ff @(posedge aclk) begin
        if (wr_in.en) begin
            store[wr_in.addr] <= wr_in.data;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Hand request and write on to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            wr_reg.en     <= 1'b0;
        end else begin
            tok_reg <= tok_in;
            wr_reg  <= wr_in;
        end
    end

    // Add this tap's pixel into the running sums.
    always_comb begin
        tok_out       = tok_reg;
        tok_out.sum_r = tok_reg.sum_r + SUM_W'(rd_data_reg[23:16]);
        tok_out.sum_g = tok_reg.sum_g + SUM_W'(rd_data_reg[15:8]);
        tok_out.sum_b = tok_reg.sum_b + SUM_W'(rd_data_reg[7:0]);
    end

    assign wr_out = wr_reg;

endmodule

FILE: rtl/core/dmb_scale.sv
module dmb_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  dmb_pkg::cfg_t      cfg,
    input  dmb_pkg::tok_t      tok_in,
    output logic               push_valid,
    output dmb_pkg::out_word_t push_data
);
    import dmb_pkg::*;

    localparam int PROD_W = SUM_W + SCALE_W;
    localparam int SH_W   = PROD_W - 16;
    localparam int V_W    = SH_W + 2;

    logic              v1_reg, v2_reg;
    logic              last1_reg, fd1_reg;
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    out_word_t         word_reg;

    // Drop the fraction, add the bias and saturate to a byte.
    function automatic logic [7:0] finish(
        input logic [PROD_W-1:0]       prod,
        input logic signed [BIAS_W-1:0] bias
    );
        logic signed [V_W-1:0] v;
        v = signed'(V_W'(prod[PROD_W-1:16])) + V_W'(bias);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > signed'(V_W'(255))) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= tok_in.valid;
            v2_reg <= v1_reg;
        end
    end

    // Multiply stage, then bias and saturation stage.
    always_ff @(posedge aclk) begin
        prod_r_reg <= PROD_W'(tok_in.sum_r) * PROD_W'(cfg.scale_q16);
        prod_g_reg <= PROD_W'(tok_in.sum_g) * PROD_W'(cfg.scale_q16);
        prod_b_reg <= PROD_W'(tok_in.sum_b) * PROD_W'(cfg.scale_q16);
        last1_reg  <= tok_in.last;
        fd1_reg    <= tok_in.frame_done;
        word_reg.out_red     <= finish(prod_r_reg, cfg.bias);
        word_reg.out_green   <= finish(prod_g_reg, cfg.bias);
        word_reg.out_blue    <= finish(prod_b_reg, cfg.bias);
        word_reg.last_in_run <= last1_reg;
        word_reg.frame_done  <= fd1_reg;
    end

    assign push_valid = v2_reg;
    assign push_data  = word_reg;

endmodule

FILE: rtl/core/dmb_fifo.sv
module dmb_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  dmb_pkg::out_word_t push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dmb_pkg::out_word_t m_data
);
    import dmb_pkg::*;

    out_word_t             buf_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = buf_mem[rd_ptr_reg];

    // Pointers and fill level; space is reserved upstream before a word starts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push_valid) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: dv/diagonal_motion_blur_convolver_test.sv
`timescale 1ns / 1ps

module diagonal_motion_blur_convolver_test;
    import dmb_pkg::*;

    // An index outside the register map; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_word_t s_data;
    logic m_valid;
    logic m_ready;
    out_word_t m_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    diagonal_motion_blur_convolver dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    // Mirror of the block: pixel rows, stream positions and settings.
    logic [PIX_W-1:0] row_pixels [0:STORE_DEPTH-1];
    int col_in, row_in, col_out, row_out;
    logic [WIDTH_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic signed [BIAS_W-1:0] bias_reg;

    in_word_t pending_words[$];
    out_word_t blurred_words[$];
    int errors;
    int words_in;
    int words_out;
    int frames_done;
    int cycles;
    bit no_idle;
    bit word_taken;
    bit hold_started;
    int hold_left;

    function automatic int used_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int used_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic logic [7:0] scale_channel(int sum);
        longint v;
        v = ((longint'(sum) * longint'(scale_reg)) >>> 16) + longint'(bias_reg);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic bit window_complete(int w, int h);
        int c;
        int r;
        c = col_out + HALF_K;
        r = row_out + HALF_K;
        if (c > w - 1) c = w - 1;
        if (r > h - 1) r = h - 1;
        return row_in > r || (row_in == r && col_in > c);
    endfunction

    // Sum the diagonal taps for the next output position and queue the result.
    task automatic blur_next(int w, int h);
        out_word_t o;
        int sr;
        int sg;
        int sb;
        int cx;
        int cy;
        logic [PIX_W-1:0] px;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            cx = col_out - HALF_K + k;
            cy = row_out - HALF_K + k;
            if (cx < 0) cx = 0;
            if (cx > w - 1) cx = w - 1;
            if (cy < 0) cy = 0;
            if (cy > h - 1) cy = h - 1;
            px = row_pixels[(cy % KERNEL_SIZE) * MAX_WIDTH + cx];
            sr += int'(px[23:16]);
            sg += int'(px[15:8]);
            sb += int'(px[7:0]);
        end
        o.out_red = scale_channel(sr);
        o.out_green = scale_channel(sg);
        o.out_blue = scale_channel(sb);
        o.last_in_run = 1'b0;
        o.frame_done = (col_out == w - 1 && row_out == h - 1);
        if (o.frame_done) begin
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
        end else begin
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out++;
            end
        end
        blurred_words.push_back(o);
    endtask

    // Work out every result that one accepted input word causes.
    task automatic predict_word(in_word_t iw);
        int w;
        int h;
        int r;
        int n;
        w = used_width();
        h = used_height();
        n = 0;
        if (iw.kind == KIND_PIXEL) begin
            r = row_in;
            if (r >= h) return;
            row_pixels[(r % KERNEL_SIZE) * MAX_WIDTH + col_in] = {iw.red, iw.green, iw.blue};
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            while (n < HALF_K + 1 && row_out + HALF_K <= r && row_out < h
                   && window_complete(w, h)) begin
                blur_next(w, h);
                n++;
            end
        end else if (row_out < h && window_complete(w, h)) begin
            blur_next(w, h);
            n = 1;
        end
        if (n > 0) blurred_words[$].last_in_run = 1'b1;
    endtask

    // Write one register, both in the block and in the mirror.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_IMAGE_WIDTH: width_reg = value[WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT: height_reg = value[HEIGHT_W-1:0];
            CFG_SCALE_Q16: scale_reg = value[SCALE_W-1:0];
            CFG_BIAS: bias_reg = value[BIAS_W-1:0];
            default: ;
        endcase
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int scale, int b);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_SCALE_Q16, CFG_DATA_W'(scale));
        write_reg(CFG_BIAS, CFG_DATA_W'(b));
    endtask

    // Wait until every word is sent and every result is back, then let the pipe empty.
    task automatic settle();
        wait (pending_words.size() == 0 && !s_valid && blurred_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic in_word_t pixel_word(int mode);
        in_word_t iw;
        iw.kind = KIND_PIXEL;
        {iw.red, iw.green, iw.blue} = PIX_W'($urandom);
        if (mode == 1) {iw.red, iw.green, iw.blue} = '0;
        if (mode == 2) {iw.red, iw.green, iw.blue} = '1;
        return iw;
    endfunction

    function automatic in_word_t flush_word();
        in_word_t iw;
        iw = $bits(in_word_t)'($urandom);
        iw.kind = KIND_FLUSH;
        return iw;
    endfunction

    // One frame of pixels with optional stray flushes (and then one extra pixel), then enough flushes to drain it.
    task automatic queue_frame(int w, int h, int noise_pct, int mode);
        int drains;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct) pending_words.push_back(flush_word());
            pending_words.push_back(pixel_word(mode));
        end
        if (noise_pct > 0) begin
            pending_words.push_back(pixel_word(0));
        end
        drains = w * ((h < HALF_K + 1) ? h : HALF_K + 1) + 1;
        for (int i = 0; i < drains; i++) pending_words.push_back(flush_word());
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles at %0t", cycles, $time);
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: offers the next word at the falling edge, idling at random.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || word_taken)) begin
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
                s_valid <= 1'b1;
                s_data <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with one long hold-off once results are flowing.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_started && words_out >= 20) begin
            hold_started <= 1'b1;
            hold_left <= 300;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 37);
        end
    end

    // Monitor: predicts on input handshakes and checks each result word.
    always @(posedge aclk) begin
        out_word_t want;
        word_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            words_in <= words_in + 1;
            predict_word(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            words_out <= words_out + 1;
            if (blurred_words.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $time, m_data);
                errors <= errors + 1;
            end else begin
                want = blurred_words.pop_front();
                if (want.frame_done) frames_done <= frames_done + 1;
                if (want.out_red !== m_data.out_red ||
                    want.out_green !== m_data.out_green ||
                    want.out_blue !== m_data.out_blue ||
                    want.last_in_run !== m_data.last_in_run ||
                    want.frame_done !== m_data.frame_done) begin
                    $display("%0t: mismatch, expected r=%0d g=%0d b=%0d last=%b done=%b",
                             $time, want.out_red, want.out_green, want.out_blue,
                             want.last_in_run, want.frame_done);
                    $display("%0t:           actual   r=%0d g=%0d b=%0d last=%b done=%b",
                             $time, m_data.out_red, m_data.out_green, m_data.out_blue,
                             m_data.last_in_run, m_data.frame_done);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        frames_done = 0;
        cycles = 0;
        no_idle = 1'b0;
        word_taken = 1'b0;
        hold_started = 1'b0;
        hold_left = 0;
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        width_reg = WIDTH_W'(1024);
        height_reg = HEIGHT_W'(768);
        scale_reg = SCALE_W'(7282);
        bias_reg = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a tiny frame, a flush with nothing ready, black and white
        // pixels, a pixel sent while the frame drains, and an unmapped index.
        set_geometry(4, 3, 7282, 0);
        write_reg(CFG_UNMAPPED, 24'hFFFFFF);
        pending_words.push_back(flush_word());
        for (int i = 0; i < 12; i++) pending_words.push_back(pixel_word((i % 2) + 1));
        pending_words.push_back(pixel_word(0));
        for (int i = 0; i < 13; i++) pending_words.push_back(flush_word());
        settle();

        // A height of 4096 rows, frame dropped part way by a geometry write.
        set_geometry(7, 4096, 24'hFFFFFF, -255);
        for (int i = 0; i < 14; i++) pending_words.push_back(pixel_word(2));
        settle();
        set_geometry(5, 6, 24'hFFFFFF, 255);
        queue_frame(5, 6, 0, 0);
        settle();

        // Random frames; one 5x5 frame runs with no idling on either side.
        for (int f = 0; f < 3; f++) begin
            no_idle = (f == 1);
            if (no_idle) begin
                set_geometry(5, 5, int'($urandom_range(24'hFFFFFF)),
                             int'($urandom_range(510)) - 255);
            end else begin
                set_geometry(int'($urandom_range(5, 1)), int'($urandom_range(5, 1)),
                             int'($urandom_range(24'hFFFFFF)),
                             int'($urandom_range(510)) - 255);
            end
            if (f % 3 == 0) write_reg(CFG_SCALE_Q16, CFG_DATA_W'($urandom_range(20000)));
            queue_frame(used_width(), used_height(), 10, 0);
            settle();
        end
        no_idle = 1'b0;

        // Width and height of zero are used as one.
        set_geometry(0, 0, 65536, 0);
        queue_frame(1, 1, 0, 0);
        settle();

        // An oversize width is clamped to the line store width; only the start
        // of the row is sent and released by flushes.
        set_geometry(2047, 1, 65536, 0);
        for (int i = 0; i < 12; i++) pending_words.push_back(pixel_word(0));
        for (int i = 0; i < 8; i++) pending_words.push_back(flush_word());
        settle();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (blurred_words.size() != 0) begin
            $display("%0d expected result words never arrived", blurred_words.size());
            errors = errors + 1;
        end
        $display("Sent %0d input words over small, tall, empty and wide frames;", words_in);
        $display("checked %0d filtered pixels, %0d frames completed.", words_out, frames_done);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
